[hdl/drive_setpoint_shaper_defines.svh]
// Assertion macros shared by the setpoint shaper RTL.
`ifndef DRIVE_SETPOINT_SHAPER_DEFINES_SVH
`define DRIVE_SETPOINT_SHAPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is high.
`define DSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds across reset.
`define DSS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSS_ASSERT(lbl, prop, msg)
`define DSS_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[hdl/dss_pkg.sv]
// Types, constants and helper functions of the drive setpoint shaper.
package dss_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPEED_DEAD_ZONE = 3'd0,
    REG_STEER_DEAD_ZONE = 3'd1,
    REG_STEER_LIMIT     = 3'd2,
    REG_STEER_SLEW_RATE = 3'd3,
    REG_ZERO_CROSS_ZONE = 3'd4,
    REG_ACCEL_RATE      = 3'd5,
    REG_BRAKE_RATE      = 3'd6,
    REG_RX_TIMEOUT      = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [10:0] SPEED_DEAD_ZONE_RST = 11'd500;
  localparam logic [9:0]  STEER_DEAD_ZONE_RST = 10'd100;
  localparam logic [13:0] STEER_LIMIT_RST     = 14'd3000;
  localparam logic [15:0] STEER_SLEW_RATE_RST = 16'd12000;
  localparam logic [10:0] ZERO_CROSS_ZONE_RST = 11'd300;
  localparam logic [15:0] ACCEL_RATE_RST      = 16'd1000;
  localparam logic [15:0] BRAKE_RATE_RST      = 16'd4000;
  localparam logic [15:0] RX_TIMEOUT_RST      = 16'd500;

  // floor(x / 1000) for x < 2^24: ceil(2^34 / 1000) with a 34-bit shift is exact
  localparam logic [24:0] DIV1000_MUL = 25'd17179870;
  localparam int          DIV1000_SHIFT = 34;

  // cdeg to mrad: floor(x * 1570796327 / 9e9), exact for x <= 16384 with a 48-bit shift
  localparam logic [127:0] MRAD_NUM = 128'd1570796327 << 48;
  localparam logic [45:0]  MRAD_MUL = 46'((MRAD_NUM + 128'd8999999999) / 128'd9000000000);
  localparam logic [22:0]  MRAD_MUL_LO = MRAD_MUL[22:0];
  localparam logic [22:0]  MRAD_MUL_HI = MRAD_MUL[45:23];
  localparam logic [10:0]  MRAD_MAX = 11'd2047;

  // Ramp step: floor(rate * dt / 1000), rate * dt already formed
  function automatic logic [14:0] div1000(input logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'(DIV1000_MUL);
    return p[DIV1000_SHIFT +: 15];
  endfunction

endpackage

[hdl/drive_setpoint_shaper.sv]
// Drive setpoint shaper: dead zones, steering clamp and slew limiting per control tick.
//
//  channel   direction  payload (low bit first)
//  s_axis    in         tuser: has_cmd; tdata: cmd_speed, cmd_steer, elapsed_ms
//  m_axis    out        tdata: remote_mode, speed_ref, steering_ref, steering_mrad,
//                              servo_enable, pid_reset
//  cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle sustained while m_axis_tready allows; a beat passes the capture,
// divide, mode, partial-product and result stages. The mode and reference state closes
// its loop in the third stage; ramp steps and the milliradian product are formed in
// stages around it. rst clears all stage valids and state and loads the register defaults.
// A stall on m_axis backs up stage by stage; empty stages keep filling.
`include "drive_setpoint_shaper_defines.svh"

module drive_setpoint_shaper (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  dss_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  // input ticks
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,   // cmd_speed[15:0], cmd_steer[31:16], elapsed_ms[39:32]
  input  logic [0:0]        s_axis_tuser,   // has_cmd[0]
  // output references
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata    // remote_mode[0], speed_ref[16:1],
                                            // steering_ref[31:17], steering_mrad[43:32],
                                            // servo_enable[44], pid_reset[45], zero[47:46]
);
  import dss_pkg::*;

  // ---------------------------------------------------------------- config
  logic [10:0] speed_dead_zone;
  logic [9:0]  steer_dead_zone;
  logic [13:0] steer_limit;
  logic [15:0] steer_slew_rate;
  logic [10:0] zero_cross_zone;
  logic [15:0] accel_rate;
  logic [15:0] brake_rate;
  logic [15:0] rx_timeout;

  // Load register defaults, then take writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_dead_zone <= SPEED_DEAD_ZONE_RST;
      steer_dead_zone <= STEER_DEAD_ZONE_RST;
      steer_limit     <= STEER_LIMIT_RST;
      steer_slew_rate <= STEER_SLEW_RATE_RST;
      zero_cross_zone <= ZERO_CROSS_ZONE_RST;
      accel_rate      <= ACCEL_RATE_RST;
      brake_rate      <= BRAKE_RATE_RST;
      rx_timeout      <= RX_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_DEAD_ZONE: speed_dead_zone <= cfg_data[10:0];
        REG_STEER_DEAD_ZONE: steer_dead_zone <= cfg_data[9:0];
        REG_STEER_LIMIT:     steer_limit     <= cfg_data[13:0];
        REG_STEER_SLEW_RATE: steer_slew_rate <= cfg_data;
        REG_ZERO_CROSS_ZONE: zero_cross_zone <= cfg_data[10:0];
        REG_ACCEL_RATE:      accel_rate      <= cfg_data;
        REG_BRAKE_RATE:      brake_rate      <= cfg_data;
        REG_RX_TIMEOUT:      rx_timeout      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic st_go;

  // A stage loads when it is empty or its contents move on
  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign st_go = rdy3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // ---------------------------------------------------------------- stage 1: capture, rate * dt
  logic [7:0]  dt_in;
  logic        p1_has_cmd;
  logic [15:0] p1_speed, p1_steer;
  logic [7:0]  p1_dt;
  logic [23:0] p1_acc_prod, p1_brk_prod, p1_str_prod;

  assign dt_in = s_axis_tdata[39:32];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_has_cmd  <= s_axis_tuser[0];
      p1_speed    <= s_axis_tdata[15:0];
      p1_steer    <= s_axis_tdata[31:16];
      p1_dt       <= dt_in;
      p1_acc_prod <= 24'(accel_rate) * 24'(dt_in);
      p1_brk_prod <= 24'(brake_rate) * 24'(dt_in);
      p1_str_prod <= 24'(steer_slew_rate) * 24'(dt_in);
    end
  end

  // ---------------------------------------------------------------- stage 2: divide by 1000
  logic        p2_has_cmd;
  logic [15:0] p2_speed, p2_steer;
  logic [7:0]  p2_dt;
  logic [14:0] p2_acc_step, p2_brk_step, p2_str_step;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_has_cmd  <= p1_has_cmd;
      p2_speed    <= p1_speed;
      p2_steer    <= p1_steer;
      p2_dt       <= p1_dt;
      p2_acc_step <= div1000(p1_acc_prod);
      p2_brk_step <= div1000(p1_brk_prod);
      p2_str_step <= div1000(p1_str_prod);
    end
  end

  // ---------------------------------------------------------------- stage 3: mode and references
  logic        mode_is_remote;
  logic [15:0] latched_speed, latched_steer;
  logic [15:0] silence_age;
  logic [15:0] speed_reference;
  logic [14:0] steer_track;
  logic        prev_speed_nonzero;

  logic [16:0] age_sum;
  logic [15:0] silence_age_next;
  logic [15:0] latched_speed_next, latched_steer_next;
  logic        mode_next, mode_changed;
  logic [15:0] spd_cur;
  logic [14:0] str_cur;
  logic        pnz_cur;
  logic [16:0] spd_mag, str_mag, base_mag;
  logic [15:0] v_tgt, s_dz;
  logic signed [16:0] s_ext, lim_pos, lim_neg, s_clip;
  logic [14:0] s_tgt;
  logic        drop, low_speed, reversing;
  logic [15:0] spd_base;
  logic        base_pos, base_neg, v_pos, v_neg;
  logic [14:0] spd_step;
  logic signed [16:0] spd_d, spd_stp;
  logic signed [15:0] str_d, str_stp;
  logic [15:0] spd_slew;
  logic [14:0] str_slew;
  logic [15:0] speed_reference_next;
  logic [14:0] steer_track_next;
  logic        prev_speed_nonzero_next;
  logic        pid_next;

  always_comb begin
    // Age the silence counter, saturating, then apply a command
    age_sum = {1'b0, silence_age} + 17'(p2_dt);
    silence_age_next = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    latched_speed_next = latched_speed;
    latched_steer_next = latched_steer;
    mode_next = mode_is_remote;
    if (p2_has_cmd) begin
      latched_speed_next = p2_speed;
      latched_steer_next = p2_steer;
      silence_age_next = '0;
      mode_next = 1'b1;
    end
    if (!(silence_age_next < rx_timeout)) mode_next = 1'b0;
    mode_changed = mode_next != mode_is_remote;

    // Clear references on a mode change
    spd_cur = mode_changed ? '0 : speed_reference;
    str_cur = mode_changed ? '0 : steer_track;
    pnz_cur = mode_changed ? 1'b0 : prev_speed_nonzero;

    // Dead zones
    spd_mag = latched_speed_next[15] ? (17'd0 - {1'b1, latched_speed_next})
                                     : {1'b0, latched_speed_next};
    str_mag = latched_steer_next[15] ? (17'd0 - {1'b1, latched_steer_next})
                                     : {1'b0, latched_steer_next};
    v_tgt = (spd_mag < 17'(speed_dead_zone)) ? '0 : latched_speed_next;
    s_dz  = (str_mag < 17'(steer_dead_zone)) ? '0 : latched_steer_next;

    // Steering clamp
    s_ext   = signed'({s_dz[15], s_dz});
    lim_pos = signed'({3'b000, steer_limit});
    lim_neg = -lim_pos;
    if (s_ext > lim_pos)      s_clip = lim_pos;
    else if (s_ext < lim_neg) s_clip = lim_neg;
    else                      s_clip = s_ext;
    s_tgt = s_clip[14:0];

    // Speed command dropped to zero
    drop = (v_tgt == '0) && pnz_cur;
    spd_base = drop ? '0 : spd_cur;

    // Pick the speed slew rate
    base_mag = spd_base[15] ? (17'd0 - {1'b1, spd_base}) : {1'b0, spd_base};
    low_speed = base_mag < 17'(zero_cross_zone);
    base_neg = spd_base[15];
    base_pos = !spd_base[15] && (spd_base != '0);
    v_neg = v_tgt[15];
    v_pos = !v_tgt[15] && (v_tgt != '0);
    reversing = (base_pos && v_neg) || (base_neg && v_pos);
    spd_step = (low_speed || reversing) ? p2_brk_step : p2_acc_step;

    // Speed ramp
    spd_d   = signed'({v_tgt[15], v_tgt}) - signed'({spd_base[15], spd_base});
    spd_stp = signed'({2'b00, spd_step});
    if (spd_d > spd_stp)       spd_slew = spd_base + 16'(spd_step);
    else if (spd_d < -spd_stp) spd_slew = spd_base - 16'(spd_step);
    else                       spd_slew = v_tgt;

    // Steering ramp
    str_d   = signed'({s_tgt[14], s_tgt}) - signed'({str_cur[14], str_cur});
    str_stp = signed'({1'b0, p2_str_step});
    if (str_d > str_stp)       str_slew = str_cur + p2_str_step;
    else if (str_d < -str_stp) str_slew = str_cur - p2_str_step;
    else                       str_slew = s_tgt;

    // Local mode holds references at zero
    if (mode_next) begin
      speed_reference_next    = spd_slew;
      steer_track_next        = str_slew;
      prev_speed_nonzero_next = v_tgt != '0;
    end else begin
      speed_reference_next    = '0;
      steer_track_next        = '0;
      prev_speed_nonzero_next = pnz_cur;
    end
    pid_next = mode_changed || (mode_next && drop);
  end

  logic        p3_remote, p3_pid;
  logic [15:0] p3_speed;
  logic [14:0] p3_steer;

  // Advance state once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_is_remote     <= 1'b0;
      latched_speed      <= '0;
      latched_steer      <= '0;
      silence_age        <= 16'hFFFF;
      speed_reference    <= '0;
      steer_track        <= '0;
      prev_speed_nonzero <= 1'b0;
    end else if (st_go) begin
      mode_is_remote     <= mode_next;
      latched_speed      <= latched_speed_next;
      latched_steer      <= latched_steer_next;
      silence_age        <= silence_age_next;
      speed_reference    <= speed_reference_next;
      steer_track        <= steer_track_next;
      prev_speed_nonzero <= prev_speed_nonzero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p3_remote <= mode_next;
      p3_pid    <= pid_next;
      p3_speed  <= speed_reference_next;
      p3_steer  <= steer_track_next;
    end
  end

  // ---------------------------------------------------------------- stage 4: mrad partial products
  logic [14:0] str_abs;
  logic        p4_remote, p4_pid, p4_neg;
  logic [15:0] p4_speed;
  logic [14:0] p4_steer;
  logic [37:0] p4_hi, p4_lo;

  assign str_abs = p3_steer[14] ? (~p3_steer + 15'd1) : p3_steer;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      p4_remote <= p3_remote;
      p4_pid    <= p3_pid;
      p4_speed  <= p3_speed;
      p4_steer  <= p3_steer;
      p4_neg    <= p3_steer[14];
      p4_hi     <= 38'(str_abs) * 38'(MRAD_MUL_HI);
      p4_lo     <= 38'(str_abs) * 38'(MRAD_MUL_LO);
    end
  end

  // ---------------------------------------------------------------- stage 5: mrad sum, result beat
  logic [60:0] mrad_sum;
  logic [12:0] mrad_raw;
  logic [10:0] mrad_mag;
  logic [11:0] mrad_val;
  logic        o_remote, o_pid;
  logic [15:0] o_speed;
  logic [14:0] o_steer;
  logic [11:0] o_mrad;
  logic        o_refs_zero;

  always_comb begin
    mrad_sum = {p4_hi, 23'd0} + 61'(p4_lo);
    mrad_raw = mrad_sum[60:48];
    mrad_mag = (mrad_raw > 13'(MRAD_MAX)) ? MRAD_MAX : mrad_raw[10:0];
    mrad_val = p4_neg ? (12'd0 - {1'b0, mrad_mag}) : {1'b0, mrad_mag};
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      o_remote <= p4_remote;
      o_pid    <= p4_pid;
      o_speed  <= p4_speed;
      o_steer  <= p4_steer;
      o_mrad   <= mrad_val;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {2'b00, o_pid, o_remote, o_mrad, o_steer, o_speed, o_remote};
  assign o_refs_zero   = (o_speed == '0) && (o_steer == '0) && (o_mrad == '0);

  // ---------------------------------------------------------------- checks
  `DSS_ASSERT(a_local_outputs_zero, (v5 && !o_remote) |-> o_refs_zero, "local beat not zero")
  `DSS_ASSERT(a_mrad_sign, (v5 && !o_steer[14]) |-> !o_mrad[11], "mrad sign wrong")
  `DSS_ASSERT(a_cmd_clears_age, (st_go && p2_has_cmd) |=> (silence_age == '0), "age kept")
  `DSS_ASSERT_NR(a_reset_empties, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the drive setpoint shaper: directed, extreme and random ticks.
`timescale 1ns / 100ps

module tb_top;
  import dss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 5;
  localparam int TICKS_PER_PHASE = 210;
  // Documented upper bound of each register, in index order
  localparam int REG_HIGH [8] = '{2000, 1000, 9000, 65535, 2000, 65535, 65535, 65535};

  // One expected output beat, fields widened to int
  typedef struct {
    int remote_mode;
    int speed_ref;
    int steering_ref;
    int steering_mrad;
    int servo_enable;
    int pid_reset;
  } ref_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = REG_SPEED_DEAD_ZONE;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // cmd_speed[15:0], cmd_steer[31:16], elapsed_ms[39:32]
  logic [0:0]  s_axis_tuser = '0;   // has_cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // remote_mode[0], speed_ref[16:1], steering_ref[31:17],
                                    // steering_mrad[43:32], servo_enable[44], pid_reset[45]

  // Shaper copy of the registers
  int cfg_speed_dz, cfg_steer_dz, cfg_steer_limit, cfg_steer_slew;
  int cfg_zero_zone, cfg_accel, cfg_brake, cfg_rx_timeout;
  // Shaper copy of the state
  bit st_remote;
  int st_speed_cmd, st_steer_cmd, st_age, st_speed_ref, st_steer_pos;
  bit st_prev_moving;

  ref_beat_t pending_refs [$];
  ref_beat_t head_ref;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  int        silence_left = 0;

  drive_setpoint_shaper u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("drive_setpoint_shaper test failed");
      $finish;
    end
  end

  // Stall the result side about one cycle in five, unless no_idle is set
  always @(negedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
  end

  function automatic int iabs(int x);
    return (x < 0) ? -x : x;
  endfunction

  // Move cur toward tgt by at most floor(rate * dt / 1000)
  function automatic int ramp(int cur, int tgt, int rate, int dt);
    int step;
    step = (rate * dt) / 1000;
    if (tgt - cur > step) return cur + step;
    if (tgt - cur < -step) return cur - step;
    return tgt;
  endfunction

  function automatic void load_defaults();
    cfg_speed_dz = int'(SPEED_DEAD_ZONE_RST);
    cfg_steer_dz = int'(STEER_DEAD_ZONE_RST);
    cfg_steer_limit = int'(STEER_LIMIT_RST);
    cfg_steer_slew = int'(STEER_SLEW_RATE_RST);
    cfg_zero_zone = int'(ZERO_CROSS_ZONE_RST);
    cfg_accel = int'(ACCEL_RATE_RST);
    cfg_brake = int'(BRAKE_RATE_RST);
    cfg_rx_timeout = int'(RX_TIMEOUT_RST);
    st_remote = 1'b0;
    st_speed_cmd = 0;
    st_steer_cmd = 0;
    st_age = 32'h0000FFFF;
    st_speed_ref = 0;
    st_steer_pos = 0;
    st_prev_moving = 1'b0;
  endfunction

  // Advance the shaper by one control tick and return the output beat it produces
  function automatic ref_beat_t shape_tick(bit has_cmd, logic signed [15:0] speed,
                                           logic signed [15:0] steer, logic [7:0] dt);
    ref_beat_t r;
    bit was_remote;
    bit low_speed, reversing;
    int v, s;
    longint unsigned a;
    was_remote = st_remote;
    r.pid_reset = 0;
    r.steering_mrad = 0;
    st_age = st_age + int'(dt);
    if (st_age > 32'h0000FFFF) st_age = 32'h0000FFFF;
    if (has_cmd) begin
      st_speed_cmd = int'(speed);
      st_steer_cmd = int'(steer);
      st_age = 0;
      st_remote = 1'b1;
    end
    if (st_age >= cfg_rx_timeout) st_remote = 1'b0;
    // Mode change: clear references and reset the controllers
    if (st_remote != was_remote) begin
      st_speed_ref = 0;
      st_steer_pos = 0;
      st_prev_moving = 1'b0;
      r.pid_reset = 1;
    end
    if (st_remote) begin
      v = (iabs(st_speed_cmd) < cfg_speed_dz) ? 0 : st_speed_cmd;
      s = (iabs(st_steer_cmd) < cfg_steer_dz) ? 0 : st_steer_cmd;
      if (s > cfg_steer_limit) s = cfg_steer_limit;
      if (s < -cfg_steer_limit) s = -cfg_steer_limit;
      // Speed command dropped to zero: stop at once
      if (v == 0 && st_prev_moving) begin
        st_speed_ref = 0;
        r.pid_reset = 1;
      end
      st_prev_moving = (v != 0);
      low_speed = iabs(st_speed_ref) < cfg_zero_zone;
      reversing = (st_speed_ref > 0 && v < 0) || (st_speed_ref < 0 && v > 0);
      st_speed_ref = ramp(st_speed_ref, v, (low_speed || reversing) ? cfg_brake : cfg_accel,
                          int'(dt));
      st_steer_pos = ramp(st_steer_pos, s, cfg_steer_slew, int'(dt));
      // Centidegrees to milliradians, truncated toward zero, saturated
      a = longint'(iabs(st_steer_pos));
      a = (a * 64'd3141592654) / 64'd18000000000;
      if (a > 2047) a = 2047;
      r.steering_mrad = (st_steer_pos < 0) ? -int'(a) : int'(a);
    end else begin
      st_speed_ref = 0;
      st_steer_pos = 0;
    end
    r.remote_mode = int'(st_remote);
    r.servo_enable = int'(st_remote);
    r.speed_ref = st_speed_ref;
    r.steering_ref = st_steer_pos;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_refs.size() == 0) begin
        $error("result beat with no expectation pending: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        head_ref = pending_refs.pop_front();
        check_field("remote_mode", head_ref.remote_mode, int'(m_axis_tdata[0]));
        check_field("speed_ref", head_ref.speed_ref, int'($signed(m_axis_tdata[16:1])));
        check_field("steering_ref", head_ref.steering_ref,
                    int'($signed(m_axis_tdata[31:17])));
        check_field("steering_mrad", head_ref.steering_mrad,
                    int'($signed(m_axis_tdata[43:32])));
        check_field("servo_enable", head_ref.servo_enable, int'(m_axis_tdata[44]));
        check_field("pid_reset", head_ref.pid_reset, int'(m_axis_tdata[45]));
      end
    end
  end

  // Write one register and mirror it, keeping only the register's width
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      REG_SPEED_DEAD_ZONE: cfg_speed_dz = int'(value[10:0]);
      REG_STEER_DEAD_ZONE: cfg_steer_dz = int'(value[9:0]);
      REG_STEER_LIMIT:     cfg_steer_limit = int'(value[13:0]);
      REG_STEER_SLEW_RATE: cfg_steer_slew = int'(value);
      REG_ZERO_CROSS_ZONE: cfg_zero_zone = int'(value[10:0]);
      REG_ACCEL_RATE:      cfg_accel = int'(value);
      REG_BRAKE_RATE:      cfg_brake = int'(value);
      REG_RX_TIMEOUT:      cfg_rx_timeout = int'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all_regs(logic [15:0] value);
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), value);
  endtask

  // Send one tick beat, with random idle cycles ahead of it unless no_idle is set
  task automatic send_tick(bit has_cmd, logic signed [15:0] speed, logic signed [15:0] steer,
                           logic [7:0] dt);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = has_cmd;
    s_axis_tdata = {dt, steer, speed};
    do @(posedge clk); while (!s_axis_tready);
    pending_refs.push_back(shape_tick(has_cmd, speed, steer, dt));
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_refs.size() != 0) @(posedge clk);
  endtask

  task automatic test_default_regs();
    send_tick(0, 16'sd0, 16'sd0, 8'd0);             // local after reset
    send_tick(1, 16'sd32767, 16'sd18000, 8'd255);   // enter remote
    send_tick(0, 16'sd0, 16'sd0, 8'd100);
    send_tick(1, -16'sd32768, -16'sd18000, 8'd255); // reversal uses brake rate
    send_tick(1, 16'sd0, 16'sd0, 8'd50);            // drop to zero speed
    send_tick(1, 16'sd499, 16'sd99, 8'd20);         // just inside dead zones
    send_tick(1, 16'sd500, 16'sd100, 8'd20);        // at dead zone edges
    send_tick(1, -16'sd500, -16'sd100, 8'd255);
    send_tick(1, 16'sd1000, 16'sd3001, 8'd0);       // zero dt, steering clamp
    send_tick(0, 16'sd0, 16'sd0, 8'd255);
    send_tick(0, 16'sd0, 16'sd0, 8'd255);           // silence timeout
    send_tick(0, 16'sd0, 16'sd0, 8'd255);
    send_tick(1, 16'sd32767, -16'sd18000, 8'd1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // All zero: timeout of zero keeps local mode even on a command
    write_all_regs(16'h0000);
    send_tick(1, 16'sd100, 16'sd100, 8'd10);
    send_tick(0, -16'sd1, -16'sd1, 8'd255);
    wait_drained();
    // All ones: each register keeps its low bits, steering past the mrad range
    write_all_regs(16'hFFFF);
    send_tick(1, 16'sd32767, 16'sd18000, 8'd255);
    send_tick(1, -16'sd32768, -16'sd18000, 8'd255);
    send_tick(1, 16'sd2047, 16'sd1023, 8'd10);
    send_tick(1, 16'sd2046, 16'sd1022, 8'd10);
    wait_drained();
    // Clamp tighter than the steering dead zone
    write_reg(REG_SPEED_DEAD_ZONE, 16'd0);
    write_reg(REG_STEER_DEAD_ZONE, 16'd1000);
    write_reg(REG_STEER_LIMIT, 16'd200);
    write_reg(REG_RX_TIMEOUT, 16'd1);
    send_tick(1, 16'sd0, 16'sd1000, 8'd255);
    send_tick(1, 16'sd0, -16'sd999, 8'd255);
    send_tick(1, 16'sd1, -16'sd18000, 8'd255);
    wait_drained();
  endtask

  // Mostly in-range settings, with extremes and raw 16-bit writes mixed in
  task automatic randomize_regs();
    int value;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(7))
        0: value = int'($urandom_range(0, 65535));
        1: value = $urandom_range(1) ? REG_HIGH[i] : 0;
        default: value = int'($urandom_range(0, REG_HIGH[i]));
      endcase
      if (cfg_idx_t'(i) == REG_RX_TIMEOUT && $urandom_range(7) != 0)
        value = int'($urandom_range(20, 1000));
      write_reg(cfg_idx_t'(i), value[15:0]);
    end
  endtask

  // Command bursts with random content, occasional silences long enough to time out
  task automatic send_random_tick();
    bit has_cmd;
    logic signed [15:0] speed, steer;
    logic [7:0] dt;
    if (silence_left > 0) begin
      silence_left--;
      has_cmd = 1'b0;
    end else begin
      has_cmd = ($urandom_range(99) < 40);
      if ($urandom_range(99) < 3) silence_left = int'($urandom_range(5, 40));
    end
    dt = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
    case ($urandom_range(5))
      0: speed = 16'sd0;
      1: speed = 16'(cfg_speed_dz + int'($urandom_range(0, 4)) - 2);
      2: speed = 16'($urandom);
      3: speed = 16'(int'($urandom_range(0, 6000)) - 3000);
      4: speed = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
      default: speed = 16'(int'($urandom_range(0, 1000)) - 500);
    endcase
    if (speed != -16'sd32768 && $urandom_range(1)) speed = -speed;
    case ($urandom_range(3))
      0: steer = 16'sd0;
      1: steer = 16'(cfg_steer_dz + int'($urandom_range(0, 4)) - 2);
      2: steer = 16'(int'($urandom_range(0, 36000)) - 18000);
      default: steer = 16'sd18000;
    endcase
    if ($urandom_range(1)) steer = -steer;
    send_tick(has_cmd, speed, steer, dt);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      randomize_regs();
      no_idle = (p == 1);
      silence_left = 0;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        send_random_tick();
        if (p == 2 && n == TICKS_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    load_defaults();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_regs();
    test_register_extremes();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("drive_setpoint_shaper test passed");
    end else begin
      $display("drive_setpoint_shaper test failed");
    end
    $finish;
  end

endmodule
